@@ sv/rled_pkg.sv @@
// Shared types, codes and constants of the run-length image decoder.
`timescale 1ns / 1ps
package rled_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned UNIT_W      = 13;
  localparam int unsigned TOTAL_W     = 25;
  localparam int unsigned ROWPROD_W   = 24;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned RECIP_BITS  = 16;
  localparam int unsigned RECIP_W     = RECIP_BITS + 1;
  localparam int unsigned SMALL_UNITS = 128;
  localparam int unsigned SMALL_IDX_W = 7;
  localparam int unsigned SMALL_N     = 1 << RUN_W;
  localparam int unsigned DIV_STEPS   = UNIT_W;
  localparam int unsigned CNT_W       = 4;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    REG_DEPTH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_8  = 3'd1,
    DEPTH_16 = 3'd2,
    DEPTH_24 = 3'd3,
    DEPTH_32 = 3'd4
  } depth_e;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ADV_IDLE   = 2'd0,
    ADV_FAST   = 2'd1,
    ADV_DIV    = 2'd2,
    ADV_SETTLE = 2'd3
  } adv_state_e;

  typedef struct packed {
    logic [2:0]           depth;
    logic [UNIT_W-1:0]    units;
    logic [TOTAL_W-1:0]   total;
    logic [RECIP_W-1:0]   recip;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [ROWPROD_W-1:0] rowprod;
    logic                 busy;
  } pos_t;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic              literal;
    logic [UNIT_W-1:0] n;
  } adv_req_t;

endpackage

@@ sv/rled_cfg.sv @@
// Configuration registers and the frame geometry derived from them.
`timescale 1ns / 1ps
module rled_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_addr_i,
  input  logic [rled_pkg::CFG_W-1:0]  cfg_wdata_i,
  output rled_pkg::cfg_t              cfg_o
);
  import rled_pkg::*;

  logic [2:0]         depth_q;
  logic [CFG_W-1:0]   width_q;
  logic [CFG_W-1:0]   height_q;
  logic [UNIT_W-1:0]  w_sat;
  logic [UNIT_W-1:0]  h_sat;
  logic [UNIT_W-1:0]  units;
  logic [TOTAL_W-1:0] total_d, total_q;
  logic [RECIP_W-1:0] recip_d, recip_q;
  logic [RECIP_W-1:0] recip_tab [SMALL_UNITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DEPTH_8;
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DEPTH:  depth_q  <= cfg_wdata_i[2:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Reciprocals of the small line widths, scaled by two to the sixteenth.
  assign recip_tab[0] = '0;
  for (genvar g = 1; g < SMALL_UNITS; g++) begin : g_recip
    localparam int unsigned Val = ((1 << RECIP_BITS) + g - 1) / g;
    assign recip_tab[g] = RECIP_W'(Val);
  end

  always_comb begin
    if (width_q == '0) begin
      w_sat = UNIT_W'(1);
    end else if (width_q > UNIT_W'(MAX_WIDTH)) begin
      w_sat = UNIT_W'(MAX_WIDTH);
    end else begin
      w_sat = width_q;
    end
    if (height_q == '0) begin
      h_sat = UNIT_W'(1);
    end else if (height_q > UNIT_W'(MAX_HEIGHT)) begin
      h_sat = UNIT_W'(MAX_HEIGHT);
    end else begin
      h_sat = height_q;
    end
    units   = (depth_q == DEPTH_1) ? ((w_sat + UNIT_W'(7)) >> 3) : w_sat;
    total_d = TOTAL_W'(units) * TOTAL_W'(h_sat);
    recip_d = (units < UNIT_W'(SMALL_UNITS)) ? recip_tab[units[SMALL_IDX_W-1:0]] : '0;
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    recip_q <= recip_d;
  end

  assign cfg_o.depth = depth_q;
  assign cfg_o.units = units;
  assign cfg_o.total = total_q;
  assign cfg_o.recip = recip_q;

endmodule

@@ sv/rled_adv.sv @@
// Raster position tracker: row, column and row offset, advanced after each run.
`timescale 1ns / 1ps
module rled_adv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rled_pkg::cfg_t      cfg_i,
  input  rled_pkg::adv_req_t  req_i,
  output rled_pkg::pos_t      pos_o
);
  import rled_pkg::*;

  adv_state_e             state_d, state_q;
  logic [COORD_W-1:0]     row_d, row_q;
  logic [COORD_W-1:0]     col_d, col_q;
  logic [ROWPROD_W-1:0]   rowprod_d, rowprod_q;
  logic [UNIT_W-1:0]      n_d, n_q;
  logic [RUN_W-1:0]       q_d, q_q;
  logic [COORD_W-1:0]     drem_d, drem_q;
  logic [CNT_W-1:0]       cnt_d, cnt_q;

  logic [TOTAL_W-1:0]         rp_full;
  logic [RUN_W+UNIT_W-1:0]    qw;
  logic [RUN_W+RECIP_W-1:0]   rprod;
  logic [RUN_W-1:0]           q_fast;
  logic                       below_2w;
  logic                       small_ok;
  logic [UNIT_W-1:0]          trial;
  logic                       ge;
  logic [COORD_W-1:0]         drem_nx;
  logic [UNIT_W-1:0]          n_div;

  assign rp_full  = TOTAL_W'(row_q) * TOTAL_W'(cfg_i.units);
  assign qw       = (RUN_W+UNIT_W)'(q_q) * (RUN_W+UNIT_W)'(cfg_i.units);
  assign rprod    = (RUN_W+RECIP_W)'(req_i.n[RUN_W-1:0]) * (RUN_W+RECIP_W)'(cfg_i.recip);
  assign below_2w = {1'b0, req_i.n} < {cfg_i.units, 1'b0};
  assign small_ok = (cfg_i.units < UNIT_W'(SMALL_UNITS)) && (req_i.n < UNIT_W'(SMALL_N));
  assign q_fast   = below_2w ? RUN_W'(req_i.n >= cfg_i.units) : rprod[RECIP_BITS +: RUN_W];

  assign trial    = {drem_q, n_q[UNIT_W-1]};
  assign ge       = trial >= cfg_i.units;
  assign drem_nx  = ge ? COORD_W'(trial - cfg_i.units) : trial[COORD_W-1:0];
  assign n_div    = {n_q[UNIT_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ADV_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      rowprod_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      rowprod_q <= rowprod_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    q_q    <= q_d;
    drem_q <= drem_d;
  end

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    rowprod_d = rp_full[ROWPROD_W-1:0];
    n_d       = n_q;
    q_d       = q_q;
    drem_d    = drem_q;
    cnt_d     = cnt_q;

    unique case (state_q)
      ADV_IDLE: ;
      ADV_FAST: begin
        row_d     = row_q + COORD_W'(q_q);
        col_d     = COORD_W'(n_q - UNIT_W'(qw));
        rowprod_d = rowprod_q + ROWPROD_W'(qw);
        state_d   = ADV_IDLE;
      end
      ADV_DIV: begin
        n_d    = n_div;
        drem_d = drem_nx;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          row_d   = row_q + n_div[COORD_W-1:0];
          col_d   = drem_nx;
          state_d = ADV_SETTLE;
        end
      end
      ADV_SETTLE: state_d = ADV_IDLE;
      default: state_d = ADV_IDLE;
    endcase

    if (req_i.step) begin
      if (req_i.literal && (req_i.n < cfg_i.units)) begin
        col_d = req_i.n[COORD_W-1:0];
      end else if (req_i.literal && (req_i.n == cfg_i.units)) begin
        col_d     = '0;
        row_d     = row_q + COORD_W'(1);
        rowprod_d = rowprod_q + ROWPROD_W'(cfg_i.units);
      end else if (!req_i.literal && (below_2w || small_ok)) begin
        n_d     = req_i.n;
        q_d     = q_fast;
        state_d = ADV_FAST;
      end else begin
        n_d     = req_i.n;
        drem_d  = '0;
        cnt_d   = '0;
        state_d = ADV_DIV;
      end
    end

    if (req_i.clear) begin
      row_d     = '0;
      col_d     = '0;
      rowprod_d = '0;
      state_d   = ADV_IDLE;
    end
  end

  assign pos_o.row     = row_q;
  assign pos_o.col     = col_q;
  assign pos_o.rowprod = rowprod_q;
  assign pos_o.busy    = (state_q == ADV_DIV) || (state_q == ADV_SETTLE);

endmodule

@@ sv/rled_dec.sv @@
// Byte decode stage: input register, opcode and pixel assembly, run placement, result register.
`timescale 1ns / 1ps
module rled_dec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rled_pkg::PIX_W-1:0]     unit_value_o,
  output logic [rled_pkg::COORD_W-1:0]   start_row_o,
  output logic [rled_pkg::COORD_W-1:0]   start_col_o,
  output logic [rled_pkg::RUN_W-1:0]     run_length_o,
  output logic                           frame_done_o,
  output logic                           run_clipped_o,
  input  rled_pkg::cfg_t                 cfg_i,
  input  rled_pkg::pos_t                 pos_i,
  output rled_pkg::adv_req_t             req_o
);
  import rled_pkg::*;

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_fs_q;

  phase_e               phase_d, phase_q;
  logic [1:0]           gath_d, gath_q;
  logic [RUN_W-1:0]     rem_d, rem_q;
  logic [PIX_W-1:0]     acc_d, acc_q;
  logic                 fin_d, fin_q;

  logic                 out_valid_q;
  logic [PIX_W-1:0]     value_q;
  logic [COORD_W-1:0]   row_q;
  logic [COORD_W-1:0]   col_q;
  logic [RUN_W-1:0]     len_q;
  logic                 done_q;
  logic                 clip_q;

  logic                 out_block;
  logic                 go;
  logic                 in_take;
  logic                 fin_eff;
  phase_e               phase_eff;
  logic [2:0]           pbytes;
  logic                 gather_more;
  logic [PIX_W-1:0]     acc_new;
  logic [PIX_W-1:0]     value;
  logic [RUN_W-1:0]     count;
  logic [TOTAL_W-1:0]   pos_sum;
  logic [TOTAL_W-1:0]   left;
  logic                 beyond;
  logic                 clip;
  logic                 done;
  logic [RUN_W-1:0]     len;
  logic                 emit;

  assign out_block  = out_valid_q & out_stall_i;
  assign go         = s1_valid_q & ~out_block & ~pos_i.busy;
  assign in_stall_o = s1_valid_q & ~go;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_fs_q   <= frame_start_i;
    end
  end

  always_comb begin
    unique case (cfg_i.depth)
      DEPTH_16: pbytes = 3'd2;
      DEPTH_24: pbytes = 3'd3;
      DEPTH_32: pbytes = 3'd4;
      default:  pbytes = 3'd1;
    endcase
  end

  assign fin_eff     = s1_fs_q ? 1'b0 : fin_q;
  assign phase_eff   = s1_fs_q ? PH_OPCODE : phase_q;
  assign gather_more = ({1'b0, gath_q} + 3'd1) < pbytes;
  assign acc_new     = {acc_q[PIX_W-9:0], s1_byte_q};
  assign value       = (cfg_i.depth == DEPTH_24) ? {ALPHA_OPAQUE, acc_new[23:0]} : acc_new;
  assign count       = (phase_eff == PH_REPEAT) ? rem_q : RUN_W'(1);

  assign pos_sum = TOTAL_W'(pos_i.rowprod) + TOTAL_W'(pos_i.col);
  assign beyond  = pos_sum >= cfg_i.total;
  assign left    = cfg_i.total - pos_sum;
  assign clip    = TOTAL_W'(count) > left;
  assign done    = TOTAL_W'(count) >= left;
  assign len     = clip ? left[RUN_W-1:0] : count;

  always_comb begin
    phase_d = phase_q;
    gath_d  = gath_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    fin_d   = fin_q;
    emit    = 1'b0;
    req_o   = '0;
    req_o.n = UNIT_W'(pos_i.col) + UNIT_W'(count);

    if (go) begin
      if (s1_fs_q) begin
        fin_d       = 1'b0;
        phase_d     = PH_OPCODE;
        req_o.clear = 1'b1;
      end
      if (!fin_eff) begin
        if (phase_eff == PH_OPCODE) begin
          phase_d = s1_byte_q[7] ? PH_LITERAL : PH_REPEAT;
          rem_d   = RUN_W'(s1_byte_q[6:0]) + RUN_W'(1);
          gath_d  = '0;
          acc_d   = '0;
        end else if (gather_more) begin
          gath_d = gath_q + 2'd1;
          acc_d  = acc_new;
        end else begin
          gath_d = '0;
          acc_d  = '0;
          if (phase_eff == PH_REPEAT) begin
            rem_d   = '0;
            phase_d = PH_OPCODE;
          end else begin
            rem_d = rem_q - RUN_W'(1);
            if (rem_q == RUN_W'(1)) begin
              phase_d = PH_OPCODE;
            end
          end
          if (beyond) begin
            fin_d   = 1'b1;
            phase_d = PH_OPCODE;
            rem_d   = '0;
          end else begin
            emit = 1'b1;
            if (done) begin
              fin_d   = 1'b1;
              phase_d = PH_OPCODE;
              rem_d   = '0;
            end else begin
              req_o.step    = 1'b1;
              req_o.literal = (phase_eff == PH_LITERAL);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      gath_q      <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      gath_q      <= gath_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      fin_q       <= fin_d;
      out_valid_q <= emit | out_block;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q <= value;
      row_q   <= pos_i.row;
      col_q   <= pos_i.col;
      len_q   <= len;
      done_q  <= done;
      clip_q  <= clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign unit_value_o  = value_q;
  assign start_row_o   = row_q;
  assign start_col_o   = col_q;
  assign run_length_o  = len_q;
  assign frame_done_o  = done_q;
  assign run_clipped_o = clip_q;

endmodule

@@ sv/rle_image_decoder_top.sv @@
// Top level of the run-length image decoder.
`timescale 1ns / 1ps
//
// Channel    Direction  Handshake                  Payload
// input      in         in_valid_i / in_stall_o    data_byte_i, frame_start_i
// result     out        out_valid_o / out_stall_i  unit_value_o, start_row_o, start_col_o,
//                                                  run_length_o, frame_done_o, run_clipped_o
// config     in         cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One byte is taken per cycle unless stalled; a taken byte waits in the input register until
// decoded, and its run, if any, is presented from the result register in the next cycle.
// A repeat run that wraps lines is placed by the position tracker in the following cycle.
// A run that starts at a column past the line width after a width change may need the
// position tracker's bit-serial divider, which stalls requests while it works.
// Reset is asynchronous and active low; it brings the decoder to opcode phase at row 0.
// A request is stalled while the result register is held or the divider is busy.
module rle_image_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rled_pkg::PIX_W-1:0]    unit_value_o,
  output logic [rled_pkg::COORD_W-1:0]  start_row_o,
  output logic [rled_pkg::COORD_W-1:0]  start_col_o,
  output logic [rled_pkg::RUN_W-1:0]    run_length_o,
  output logic                          frame_done_o,
  output logic                          run_clipped_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [rled_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import rled_pkg::*;

  cfg_t     cfg;
  pos_t     pos;
  adv_req_t req;

  rled_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rled_adv u_adv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .pos_o  (pos)
  );

  rled_dec u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .unit_value_o  (unit_value_o),
    .start_row_o   (start_row_o),
    .start_col_o   (start_col_o),
    .run_length_o  (run_length_o),
    .frame_done_o  (frame_done_o),
    .run_clipped_o (run_clipped_o),
    .cfg_i         (cfg),
    .pos_i         (pos),
    .req_o         (req)
  );

endmodule

@@ bench/rle_image_decoder_checker.sv @@
// Checker for the run-length image decoder: predicts every run and compares the results.
`timescale 1ns / 1ps
module rle_image_decoder_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          frame_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rled_pkg::PIX_W-1:0]    unit_value_i,
  input  logic [rled_pkg::COORD_W-1:0]  start_row_i,
  input  logic [rled_pkg::COORD_W-1:0]  start_col_i,
  input  logic [rled_pkg::RUN_W-1:0]    run_length_i,
  input  logic                          frame_done_i,
  input  logic                          run_clipped_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [rled_pkg::CFG_W-1:0]    cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   runs_predicted_o,
  output int unsigned                   runs_checked_o,
  output int unsigned                   bytes_decoded_o,
  output int unsigned                   clipped_runs_o,
  output int unsigned                   frames_done_o
);
  import rled_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RUN_W-1:0]   len;
    logic               done;
    logic               clipped;
  } run_t;

  run_t expected_runs[$];

  logic [2:0]       depth_q  = DEPTH_8;
  logic [CFG_W-1:0] width_q  = 13'd640;
  logic [CFG_W-1:0] height_q = 13'd480;
  phase_e           phase_q  = PH_OPCODE;
  int unsigned      gathered_q, remaining_q, row_q, col_q;
  logic [PIX_W-1:0] acc_q;
  bit               finished_q;

  int unsigned failures, runs_predicted, runs_checked, bytes_decoded, clipped_runs, frames_done;

  function automatic int unsigned pixel_size();
    case (depth_q)
      DEPTH_16: return 2;
      DEPTH_24: return 3;
      DEPTH_32: return 4;
      default:  return 1;
    endcase
  endfunction

  function automatic longint unsigned line_units();
    longint unsigned w;
    w = width_q;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (depth_q == DEPTH_1) w = (w + 7) / 8;
    return w;
  endfunction

  function automatic longint unsigned frame_lines();
    longint unsigned h;
    h = height_q;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on run %0d, %s: got %h, expected %h",
             $time, runs_checked, field, got, want);
    failures++;
  endtask

  // Places a run in raster order, clipping it at the frame end.
  task automatic place_run(input logic [PIX_W-1:0] value, input int unsigned count);
    longint unsigned w, total, pos, len;
    run_t r;
    w = line_units();
    total = w * frame_lines();
    pos = row_q;
    pos = pos * w + col_q;
    len = count;
    if (pos >= total) begin
      finished_q = 1'b1;
      phase_q = PH_OPCODE;
      remaining_q = 0;
      return;
    end
    r.clipped = 1'b0;
    if (len > total - pos) begin
      len = total - pos;
      r.clipped = 1'b1;
    end
    r.value = value;
    r.row = row_q[COORD_W-1:0];
    r.col = col_q[COORD_W-1:0];
    r.len = len[RUN_W-1:0];
    pos += len;
    r.done = (pos == total);
    row_q = 32'(pos / w);
    col_q = 32'(pos % w);
    if (r.done) begin
      finished_q = 1'b1;
      phase_q = PH_OPCODE;
      remaining_q = 0;
    end
    expected_runs.push_back(r);
    runs_predicted++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [PIX_W-1:0] value;
    int unsigned count;
    if (fs) begin
      row_q = 0;
      col_q = 0;
      finished_q = 1'b0;
      phase_q = PH_OPCODE;
    end
    if (finished_q) return;
    bytes_decoded++;
    if (phase_q == PH_OPCODE) begin
      if (b <= 8'd127) begin
        phase_q = PH_REPEAT;
        remaining_q = 32'(b) + 1;
      end else begin
        phase_q = PH_LITERAL;
        remaining_q = 32'(b) - 127;
      end
      gathered_q = 0;
      acc_q = '0;
      return;
    end
    acc_q = {acc_q[PIX_W-9:0], b};
    if (gathered_q + 1 < pixel_size()) begin
      gathered_q++;
      return;
    end
    value = acc_q;
    if (depth_q == DEPTH_24) value = {ALPHA_OPAQUE, acc_q[23:0]};
    gathered_q = 0;
    acc_q = '0;
    if (phase_q == PH_REPEAT) begin
      count = remaining_q;
      remaining_q = 0;
      phase_q = PH_OPCODE;
    end else begin
      count = 1;
      remaining_q = (remaining_q - 1) & 32'hFF;
      if (remaining_q == 0) phase_q = PH_OPCODE;
    end
    if (count != 0) place_run(value, count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_t want;
    if (!rst_ni) begin
      depth_q = DEPTH_8;
      width_q = 13'd640;
      height_q = 13'd480;
      phase_q = PH_OPCODE;
      gathered_q = 0;
      remaining_q = 0;
      acc_q = '0;
      row_q = 0;
      col_q = 0;
      finished_q = 1'b0;
      expected_runs.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_DEPTH:  depth_q = cfg_wdata_i[2:0];
          REG_WIDTH:  width_q = cfg_wdata_i;
          REG_HEIGHT: height_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, frame_start_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("run with none expected, unit_value", unit_value_i, 32'd0);
        end else begin
          want = expected_runs.pop_front();
          if (unit_value_i !== want.value)
            report_mismatch("unit_value", unit_value_i, want.value);
          if (start_row_i !== want.row)
            report_mismatch("start_row", 32'(start_row_i), 32'(want.row));
          if (start_col_i !== want.col)
            report_mismatch("start_col", 32'(start_col_i), 32'(want.col));
          if (run_length_i !== want.len)
            report_mismatch("run_length", 32'(run_length_i), 32'(want.len));
          if (frame_done_i !== want.done)
            report_mismatch("frame_done", 32'(frame_done_i), 32'(want.done));
          if (run_clipped_i !== want.clipped)
            report_mismatch("run_clipped", 32'(run_clipped_i), 32'(want.clipped));
          if (want.clipped) clipped_runs++;
          if (want.done) frames_done++;
          runs_checked++;
        end
      end
    end
    fail_count_o <= failures;
    runs_predicted_o <= runs_predicted;
    runs_checked_o <= runs_checked;
    bytes_decoded_o <= bytes_decoded;
    clipped_runs_o <= clipped_runs;
    frames_done_o <= frames_done;
  end

endmodule

@@ bench/tb_rle_image_decoder_top.sv @@
// Testbench top for the run-length image decoder: stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_rle_image_decoder_top;
  import rled_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SEGMENT_BYTES   = 30;
  localparam int unsigned TIMEOUT_NS      = 5_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                frame_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PIX_W-1:0]    unit_value_o;
  logic [COORD_W-1:0]  start_row_o;
  logic [COORD_W-1:0]  start_col_o;
  logic [RUN_W-1:0]    run_length_o;
  logic                frame_done_o;
  logic                run_clipped_o;
  logic                cfg_we_i;
  logic [1:0]          cfg_addr_i;
  logic [CFG_W-1:0]    cfg_wdata_i;

  int unsigned fail_count, runs_predicted, runs_checked, bytes_decoded, clipped_runs;
  int unsigned frames_done;

  int unsigned send_idle_pct, recv_idle_pct, settings_written, bytes_sent;
  logic [2:0]  cur_depth;
  bit          hold_off_req;

  rle_image_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .unit_value_o  (unit_value_o),
    .start_row_o   (start_row_o),
    .start_col_o   (start_col_o),
    .run_length_o  (run_length_o),
    .frame_done_o  (frame_done_o),
    .run_clipped_o (run_clipped_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  rle_image_decoder_checker run_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .frame_start_i    (frame_start_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .unit_value_i     (unit_value_o),
    .start_row_i      (start_row_o),
    .start_col_i      (start_col_o),
    .run_length_i     (run_length_o),
    .frame_done_i     (frame_done_o),
    .run_clipped_i    (run_clipped_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .runs_predicted_o (runs_predicted),
    .runs_checked_o   (runs_checked),
    .bytes_decoded_o  (bytes_decoded),
    .clipped_runs_o   (clipped_runs),
    .frames_done_o    (frames_done)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The result side stalls at random, and once holds off for a long stretch on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int unsigned pixel_size(input logic [2:0] depth);
    case (depth)
      DEPTH_16: return 2;
      DEPTH_24: return 3;
      DEPTH_32: return 4;
      default:  return 1;
    endcase
  endfunction

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (runs_predicted != runs_checked) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] depth, input logic [CFG_W-1:0] width,
                            input logic [CFG_W-1:0] height);
    cur_depth = depth;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_DEPTH;
    cfg_wdata_i <= CFG_W'(depth);
    @(posedge clk_i);
    cfg_addr_i <= REG_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_addr_i <= REG_HEIGHT;
    cfg_wdata_i <= height;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  // An opcode and its pixels; now and then the pixels are cut short.
  task automatic send_packet(input logic fs);
    logic [7:0] op;
    int unsigned n;
    case ($urandom_range(7))
      0, 1, 2: op = 8'($urandom_range(7));
      3:       op = 8'($urandom_range(127));
      4, 5:    op = 8'($urandom_range(128, 131));
      6:       op = 8'($urandom_range(128, 143));
      default: begin
        case ($urandom_range(3))
          0:       op = 8'h00;
          1:       op = 8'h7F;
          2:       op = 8'h80;
          default: op = 8'hFF;
        endcase
      end
    endcase
    n = (op < 8'd128) ? 1 : 32'(op) - 127;
    n = n * pixel_size(cur_depth);
    if ($urandom_range(15) == 0) n = $urandom_range(n - 1);
    send_byte(op, fs);
    repeat (n) send_byte(pixel_byte(), 1'b0);
  endtask

  task automatic random_segment(input int unsigned quota);
    int unsigned goal;
    goal = bytes_sent + quota;
    send_packet($urandom_range(3) != 0);
    while (bytes_sent < goal) begin
      if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else send_packet($urandom_range(5) == 0);
    end
  endtask

  initial begin
    logic [2:0] depth;
    logic [CFG_W-1:0] width, height;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    frame_start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_DEPTH;
    cfg_wdata_i = '0;
    cur_depth = DEPTH_8;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings from reset: shortest and longest repeats, a literal cut by a new frame.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    drain();
    // A two-unit frame: the repeat is clipped and later bytes are ignored.
    set_config(DEPTH_24, 13'd0, 13'd2);
    send_byte(8'h05, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();
    set_config(DEPTH_32, 13'd4, 13'h1FFF);
    send_byte(8'h05, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    drain();
    // Shrinking the frame leaves the position beyond its end.
    set_config(3'd7, 13'd1, 13'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h42, 1'b0);

    for (int sec = 0; sec < 3; sec++) begin
      send_idle_pct = (sec == 0) ? 31 : (sec == 1) ? 65 : 0;
      recv_idle_pct = (sec == 0) ? 65 : (sec == 1) ? 31 : 0;
      if (sec == 2) begin
        drain();
        set_config(DEPTH_8, 13'd64, 13'd64);
        hold_off_req = 1'b1;
        send_byte(8'hA7, 1'b1);
        repeat (40) send_byte(pixel_byte(), 1'b0);
      end
      for (int ph = 0; ph < 6; ph++) begin
        drain();
        if (ph == 0) begin
          depth = (sec == 0) ? DEPTH_1 : (sec == 1) ? DEPTH_32 : 3'd7;
          width = (sec == 0) ? 13'h1FFF : (sec == 1) ? 13'd4096 : 13'd1;
          height = (sec == 0) ? 13'd0 : (sec == 1) ? 13'd4096 : 13'h1FFF;
        end else begin
          depth = ($urandom_range(15) < 13) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
          width = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 24));
          height = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 6));
        end
        set_config(depth, width, height);
        random_segment(SEGMENT_BYTES);
      end
    end
    drain();

    $display("Covered %0d sent bytes, %0d decoded, and %0d compared runs (%0d clipped, %0d %s)",
             bytes_sent, bytes_decoded, runs_checked, clipped_runs, frames_done,
             "ending a frame");
    $display("over %0d register settings, with one long hold-off on the result side.",
             settings_written);
    if (fail_count == 0 && runs_predicted == runs_checked) begin
      $display("tb_rle_image_decoder_top OK");
    end else begin
      $display("tb_rle_image_decoder_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d runs still awaited.", runs_predicted - runs_checked);
    $display("tb_rle_image_decoder_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
sv/rled_pkg.sv
sv/rled_cfg.sv
sv/rled_adv.sv
sv/rled_dec.sv
sv/rle_image_decoder_top.sv
bench/rle_image_decoder_checker.sv
bench/tb_rle_image_decoder_top.sv
